// ===== hdl/three_axis_pid_motor_mixer_macros.svh =====
// assertion macros shared by the mixer rtl
// the files that use them have clk_i and rst_ni in scope
`ifndef THREE_AXIS_PID_MOTOR_MIXER_MACROS_SVH
`define THREE_AXIS_PID_MOTOR_MIXER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define TAPM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked outside reset
`define TAPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TAPM_ASSERT(lbl, ante, cons, msg)
`define TAPM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/tapm_pkg.sv =====
`timescale 1ns / 1ps

package tapm_pkg;

  // fixed point: 1/64 degree angles, q8.8 gains, terms in 2^-14 us
  localparam int FRAC_BITS = 14;
  localparam int ANGLE_W   = 16;
  localparam int ERR_W     = 17;
  localparam int DIFF_W    = 18;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 10;
  localparam int THR_W     = 11;
  localparam int MOTOR_W   = 11;
  localparam int PROD_W    = 33;  // gain times error
  localparam int DPROD_W   = 34;  // gain times error difference
  localparam int INTEG_W   = 25;
  localparam int DERIV_W   = 33;
  localparam int TOTAL_W   = 25;
  localparam int SUM_W     = 35;
  localparam int MIX_W     = 28;

  localparam logic [THR_W-1:0]   IDLE_THROTTLE = 11'd1050;
  localparam logic [MOTOR_W-1:0] MOTOR_MIN     = 11'd1100;
  localparam logic [MOTOR_W-1:0] MOTOR_MAX     = 11'd2000;
  localparam logic [MOTOR_W-1:0] MOTOR_OFF     = 11'd1000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 10'd400;

  // stream widths
  localparam int IN_TDATA_W  = 112;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TILT_P       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_I       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_D       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_P    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_I    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_D    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_LIMIT = 3'd7;

  // per-stage loads and item flags shared by the three axis lanes
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic in_tick;
    logic in_idle;
    logic s2_tick;
    logic s2_launch;
    logic s2_idle;
  } lane_ctrl_t;

endpackage

// ===== hdl/tapm_axis_lane.sv =====
`timescale 1ns / 1ps
`include "three_axis_pid_motor_mixer_macros.svh"

module tapm_axis_lane import tapm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lane_ctrl_t                ctrl_i,
  input  logic signed [ANGLE_W-1:0] angle_i,
  input  logic signed [ANGLE_W-1:0] target_i,
  input  logic [GAIN_W-1:0]         p_gain_i,
  input  logic [GAIN_W-1:0]         i_gain_i,
  input  logic [GAIN_W-1:0]         d_gain_i,
  input  logic [LIMIT_W-1:0]        limit_i,
  output logic signed [TOTAL_W-1:0] total_o
);

  localparam logic signed [DPROD_W-1:0] D_MAX =
    {{(DPROD_W-DERIV_W+1){1'b0}}, {(DERIV_W-1){1'b1}}};
  localparam logic signed [DPROD_W-1:0] D_MIN =
    {{(DPROD_W-DERIV_W+1){1'b1}}, {(DERIV_W-1){1'b0}}};

  logic signed [ERR_W-1:0]     err_d, err_q;
  logic signed [ERR_W-1:0]     last_err_d, last_err_q;
  logic signed [DIFF_W-1:0]    diff_d, diff_q;
  logic signed [2*ERR_W-1:0]   p_full, i_full;
  logic signed [ERR_W+DIFF_W-1:0] d_full;
  logic signed [PROD_W-1:0]    pe_q, ie_q, pe3_q;
  logic signed [DPROD_W-1:0]   de_q;
  logic signed [SUM_W-1:0]     lim_s, i_sum, i_clamp, sum, sum_clamp;
  logic signed [INTEG_W-1:0]   integ_d, integ_q;
  logic signed [DERIV_W-1:0]   deriv_d, deriv_q, d_sat;
  logic signed [TOTAL_W-1:0]   total_q;

  // stage 1: error and difference against the last ticked error (cleared by an idle update)
  assign err_d  = $signed({target_i[ANGLE_W-1], target_i}) -
                  $signed({angle_i[ANGLE_W-1], angle_i});
  assign diff_d = $signed({err_d[ERR_W-1], err_d}) -
                  $signed({last_err_q[ERR_W-1], last_err_q});

  always_comb begin
    last_err_d = last_err_q;
    if (ctrl_i.ld1 && ctrl_i.in_idle) begin
      last_err_d = '0;
    end else if (ctrl_i.ld1 && ctrl_i.in_tick) begin
      last_err_d = err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
    end else begin
      last_err_q <= last_err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld1) begin
      err_q  <= err_d;
      diff_q <= diff_d;
    end
  end

  // stage 2: gain products
  assign p_full = $signed({1'b0, p_gain_i}) * err_q;
  assign i_full = $signed({1'b0, i_gain_i}) * err_q;
  assign d_full = $signed({1'b0, d_gain_i}) * diff_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld2) begin
      pe_q <= p_full[PROD_W-1:0];
      ie_q <= i_full[PROD_W-1:0];
      de_q <= d_full[DPROD_W-1:0];
    end
  end

  // stage 3: integral and derivative state
  assign lim_s = $signed({{(SUM_W-LIMIT_W-FRAC_BITS){1'b0}}, limit_i, {FRAC_BITS{1'b0}}});
  assign i_sum = $signed({{(SUM_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q}) +
                 $signed({{(SUM_W-PROD_W){ie_q[PROD_W-1]}}, ie_q});

  always_comb begin
    if (i_sum > lim_s) begin
      i_clamp = lim_s;
    end else if (i_sum < -lim_s) begin
      i_clamp = -lim_s;
    end else begin
      i_clamp = i_sum;
    end
  end

  always_comb begin
    if (de_q > D_MAX) begin
      d_sat = D_MAX[DERIV_W-1:0];
    end else if (de_q < D_MIN) begin
      d_sat = D_MIN[DERIV_W-1:0];
    end else begin
      d_sat = de_q[DERIV_W-1:0];
    end
  end

  always_comb begin
    integ_d = integ_q;
    deriv_d = deriv_q;
    if (ctrl_i.ld3) begin
      if (ctrl_i.s2_idle) begin
        integ_d = '0;
        deriv_d = '0;
      end else if (ctrl_i.s2_tick) begin
        integ_d = ctrl_i.s2_launch ? '0 : i_clamp[INTEG_W-1:0];
        deriv_d = d_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      deriv_q <= '0;
    end else begin
      integ_q <= integ_d;
      deriv_q <= deriv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld3) begin
      pe3_q <= pe_q;
    end
  end

  // stage 4: p + i + d, clamped
  assign sum = $signed({{(SUM_W-PROD_W){pe3_q[PROD_W-1]}}, pe3_q}) +
               $signed({{(SUM_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q}) +
               $signed({{(SUM_W-DERIV_W){deriv_q[DERIV_W-1]}}, deriv_q});

  always_comb begin
    if (sum > lim_s) begin
      sum_clamp = lim_s;
    end else if (sum < -lim_s) begin
      sum_clamp = -lim_s;
    end else begin
      sum_clamp = sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld4) begin
      total_q <= sum_clamp[TOTAL_W-1:0];
    end
  end

  assign total_o = total_q;

  `TAPM_ASSERT_NEXT(a_deriv_held, !(ctrl_i.ld3 && (ctrl_i.s2_tick || ctrl_i.s2_idle)), $stable(deriv_q), "derivative changed without a tick")
  `TAPM_ASSERT_NEXT(a_last_err_held, !(ctrl_i.ld1 && (ctrl_i.in_tick || ctrl_i.in_idle)), $stable(last_err_q), "last error changed without a tick")

endmodule

// ===== hdl/tapm_mixer.sv =====
`timescale 1ns / 1ps
`include "three_axis_pid_motor_mixer_macros.svh"

module tapm_mixer import tapm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      ld_i,
  input  logic                      idle_i,
  input  logic [THR_W-1:0]          thr_i,
  input  logic signed [TOTAL_W-1:0] roll_i,
  input  logic signed [TOTAL_W-1:0] pitch_i,
  input  logic signed [TOTAL_W-1:0] yaw_i,
  output logic [MOTOR_W-1:0]        left_front_o,
  output logic [MOTOR_W-1:0]        right_front_o,
  output logic [MOTOR_W-1:0]        left_back_o,
  output logic [MOTOR_W-1:0]        right_back_o
);

  localparam logic signed [MIX_W-1:0] MIX_LO =
    $signed({{(MIX_W-MOTOR_W-FRAC_BITS){1'b0}}, MOTOR_MIN, {FRAC_BITS{1'b0}}});
  localparam logic signed [MIX_W-1:0] MIX_HI =
    $signed({{(MIX_W-MOTOR_W-FRAC_BITS){1'b0}}, MOTOR_MAX, {FRAC_BITS{1'b0}}});

  function automatic logic [MOTOR_W-1:0] motor_clamp(input logic signed [MIX_W-1:0] v);
    if (v < MIX_LO) begin
      return MOTOR_MIN;
    end else if (v > MIX_HI) begin
      return MOTOR_MAX;
    end else begin
      return v[FRAC_BITS +: MOTOR_W];
    end
  endfunction

  logic signed [MIX_W-1:0] base, r, p, y;
  logic signed [MIX_W-1:0] mix_lf, mix_rf, mix_lb, mix_rb;
  logic [MOTOR_W-1:0]      lf_q, rf_q, lb_q, rb_q;

  assign base = $signed({{(MIX_W-THR_W-FRAC_BITS){1'b0}}, thr_i, {FRAC_BITS{1'b0}}});
  assign r    = $signed({{(MIX_W-TOTAL_W){roll_i[TOTAL_W-1]}}, roll_i});
  assign p    = $signed({{(MIX_W-TOTAL_W){pitch_i[TOTAL_W-1]}}, pitch_i});
  assign y    = $signed({{(MIX_W-TOTAL_W){yaw_i[TOTAL_W-1]}}, yaw_i});

  // x frame mixing
  assign mix_lf = base + r + p - y;
  assign mix_rf = base - r + p + y;
  assign mix_lb = base + r - p + y;
  assign mix_rb = base - r - p - y;

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      lf_q <= idle_i ? MOTOR_OFF : motor_clamp(mix_lf);
      rf_q <= idle_i ? MOTOR_OFF : motor_clamp(mix_rf);
      lb_q <= idle_i ? MOTOR_OFF : motor_clamp(mix_lb);
      rb_q <= idle_i ? MOTOR_OFF : motor_clamp(mix_rb);
    end
  end

  assign left_front_o  = lf_q;
  assign right_front_o = rf_q;
  assign left_back_o   = lb_q;
  assign right_back_o  = rb_q;

  `TAPM_ASSERT_NEXT(a_idle_off, ld_i && idle_i, (lf_q == MOTOR_OFF) && (rf_q == MOTOR_OFF) && (lb_q == MOTOR_OFF) && (rb_q == MOTOR_OFF), "idle throttle did not give motor off")

endmodule

// ===== hdl/three_axis_pid_motor_mixer.sv =====
`timescale 1ns / 1ps
`include "three_axis_pid_motor_mixer_macros.svh"

// three-axis pid controller with x-frame motor mixing
// input stream: one transaction per control update, carrying throttle, three
//   measured angles, three target angles, and launch/tick flags in tuser
// output stream: one transaction per input, the four motor pulse widths in us
// apb port: eight registers (gains and limits) at byte address 4*index, pready
//   tied high; the user must write them only while no transaction is in flight,
//   and the block itself does not enforce this
// throughput: one transaction per clock while m_axis_tready is high; the loops are
//   the last-error update and the integral accumulate and clamp in each axis lane
// stages: error and difference, gain multiply, integral and derivative state,
//   p+i+d clamp per lane, then the shared mixer that drives the output register
// reset: gains go to zero, limits to 400 us, all integral, derivative and
//   last-error state is cleared and the pipeline is emptied
// stall: when m_axis_tready is low the output register holds; bubbles ahead of
//   it are still filled, and s_axis_tready drops only once every stage is full
module three_axis_pid_motor_mixer import tapm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // slave stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // throttle_us, angle_x, angle_y, angle_z, roll_target, pitch_target,
  // yaw_target, zero pad
  input  logic [IN_TDATA_W-1:0]    s_axis_tdata,
  // launch_hold, period_tick
  input  logic [IN_TUSER_W-1:0]    s_axis_tuser,
  // master stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // motor_left_front, motor_right_front, motor_left_back, motor_right_back,
  // zero pad
  output logic [OUT_TDATA_W-1:0]   m_axis_tdata,
  // apb configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0]    pwdata,
  output logic [APB_DATA_W-1:0]    prdata,
  output logic                     pready
);

  // tdata field offsets
  localparam int OFF_AX = THR_W;
  localparam int OFF_AY = OFF_AX + ANGLE_W;
  localparam int OFF_AZ = OFF_AY + ANGLE_W;
  localparam int OFF_RT = OFF_AZ + ANGLE_W;
  localparam int OFF_PT = OFF_RT + ANGLE_W;
  localparam int OFF_YT = OFF_PT + ANGLE_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]    tilt_p_q, tilt_i_q, tilt_d_q;
  logic [GAIN_W-1:0]    head_p_q, head_i_q, head_d_q;
  logic [LIMIT_W-1:0]   tilt_lim_q, head_lim_q;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_p_q   <= '0;
      tilt_i_q   <= '0;
      tilt_d_q   <= '0;
      head_p_q   <= '0;
      head_i_q   <= '0;
      head_d_q   <= '0;
      tilt_lim_q <= LIMIT_RESET;
      head_lim_q <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TILT_P:        tilt_p_q   <= pwdata[GAIN_W-1:0];
        REG_TILT_I:        tilt_i_q   <= pwdata[GAIN_W-1:0];
        REG_TILT_D:        tilt_d_q   <= pwdata[GAIN_W-1:0];
        REG_HEADING_P:     head_p_q   <= pwdata[GAIN_W-1:0];
        REG_HEADING_I:     head_i_q   <= pwdata[GAIN_W-1:0];
        REG_HEADING_D:     head_d_q   <= pwdata[GAIN_W-1:0];
        REG_TILT_LIMIT:    tilt_lim_q <= pwdata[LIMIT_W-1:0];
        REG_HEADING_LIMIT: head_lim_q <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_TILT_P:        prdata = APB_DATA_W'(tilt_p_q);
      REG_TILT_I:        prdata = APB_DATA_W'(tilt_i_q);
      REG_TILT_D:        prdata = APB_DATA_W'(tilt_d_q);
      REG_HEADING_P:     prdata = APB_DATA_W'(head_p_q);
      REG_HEADING_I:     prdata = APB_DATA_W'(head_i_q);
      REG_HEADING_D:     prdata = APB_DATA_W'(head_d_q);
      REG_TILT_LIMIT:    prdata = APB_DATA_W'(tilt_lim_q);
      REG_HEADING_LIMIT: prdata = APB_DATA_W'(head_lim_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline control: each stage moves when it is empty or the next one moves
  // ---------------------------------------------------------------------------
  logic             v1_q, v2_q, v3_q, v4_q, v5_q;
  logic             en1, en2, en3, en4, en5;
  logic             ld1, ld2, ld3, ld4, ld5;
  logic [THR_W-1:0] in_thr;
  logic             in_idle, in_tick, in_launch;
  logic [THR_W-1:0] thr1_q, thr2_q, thr3_q, thr4_q;
  logic             idle1_q, idle2_q, idle3_q, idle4_q;
  logic             tick1_q, tick2_q, launch1_q, launch2_q;
  lane_ctrl_t       lane_ctrl;

  assign en5 = !v5_q || m_axis_tready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready = en1;
  assign m_axis_tvalid = v5_q;

  assign ld1 = s_axis_tvalid && en1;
  assign ld2 = v1_q && en2;
  assign ld3 = v2_q && en3;
  assign ld4 = v3_q && en4;
  assign ld5 = v4_q && en5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  assign in_thr    = s_axis_tdata[THR_W-1:0];
  assign in_idle   = (in_thr <= IDLE_THROTTLE);
  assign in_launch = s_axis_tuser[0];
  assign in_tick   = s_axis_tuser[1];

  // item flags travel beside the lane data
  always_ff @(posedge clk_i) begin
    if (ld1) begin
      thr1_q    <= in_thr;
      idle1_q   <= in_idle;
      tick1_q   <= in_tick;
      launch1_q <= in_launch;
    end
    if (ld2) begin
      thr2_q    <= thr1_q;
      idle2_q   <= idle1_q;
      tick2_q   <= tick1_q;
      launch2_q <= launch1_q;
    end
    if (ld3) begin
      thr3_q  <= thr2_q;
      idle3_q <= idle2_q;
    end
    if (ld4) begin
      thr4_q  <= thr3_q;
      idle4_q <= idle3_q;
    end
  end

  always_comb begin
    lane_ctrl.ld1       = ld1;
    lane_ctrl.ld2       = ld2;
    lane_ctrl.ld3       = ld3;
    lane_ctrl.ld4       = ld4;
    lane_ctrl.in_tick   = in_tick;
    lane_ctrl.in_idle   = in_idle;
    lane_ctrl.s2_tick   = tick2_q;
    lane_ctrl.s2_launch = launch2_q;
    lane_ctrl.s2_idle   = idle2_q;
  end

  // ---------------------------------------------------------------------------
  // axis lanes: roll uses angle y, pitch uses angle z, yaw uses angle x
  // ---------------------------------------------------------------------------
  logic signed [TOTAL_W-1:0] roll_total, pitch_total, yaw_total;

  tapm_axis_lane u_roll_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .angle_i  ($signed(s_axis_tdata[OFF_AY +: ANGLE_W])),
    .target_i ($signed(s_axis_tdata[OFF_RT +: ANGLE_W])),
    .p_gain_i (tilt_p_q),
    .i_gain_i (tilt_i_q),
    .d_gain_i (tilt_d_q),
    .limit_i  (tilt_lim_q),
    .total_o  (roll_total)
  );

  tapm_axis_lane u_pitch_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .angle_i  ($signed(s_axis_tdata[OFF_AZ +: ANGLE_W])),
    .target_i ($signed(s_axis_tdata[OFF_PT +: ANGLE_W])),
    .p_gain_i (tilt_p_q),
    .i_gain_i (tilt_i_q),
    .d_gain_i (tilt_d_q),
    .limit_i  (tilt_lim_q),
    .total_o  (pitch_total)
  );

  tapm_axis_lane u_yaw_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .angle_i  ($signed(s_axis_tdata[OFF_AX +: ANGLE_W])),
    .target_i ($signed(s_axis_tdata[OFF_YT +: ANGLE_W])),
    .p_gain_i (head_p_q),
    .i_gain_i (head_i_q),
    .d_gain_i (head_d_q),
    .limit_i  (head_lim_q),
    .total_o  (yaw_total)
  );

  // ---------------------------------------------------------------------------
  // mixer and output register
  // ---------------------------------------------------------------------------
  logic [MOTOR_W-1:0] motor_lf, motor_rf, motor_lb, motor_rb;

  tapm_mixer u_mixer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ld_i          (ld5),
    .idle_i        (idle4_q),
    .thr_i         (thr4_q),
    .roll_i        (roll_total),
    .pitch_i       (pitch_total),
    .yaw_i         (yaw_total),
    .left_front_o  (motor_lf),
    .right_front_o (motor_rf),
    .left_back_o   (motor_lb),
    .right_back_o  (motor_rb)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-4*MOTOR_W){1'b0}}, motor_rb, motor_lb, motor_rf, motor_lf};

  `TAPM_ASSERT(a_ready_when_empty, !v1_q, s_axis_tready, "input stalled with stage one empty")
  `TAPM_ASSERT(a_motor_range, m_axis_tvalid, (motor_lf >= MOTOR_OFF) && (motor_lf <= MOTOR_MAX) && (motor_rf >= MOTOR_OFF) && (motor_rf <= MOTOR_MAX) && (motor_lb >= MOTOR_OFF) && (motor_lb <= MOTOR_MAX) && (motor_rb >= MOTOR_OFF) && (motor_rb <= MOTOR_MAX), "motor value out of range")
  `TAPM_ASSERT_NEXT(a_fill_stage_one, s_axis_tvalid && s_axis_tready, v1_q, "accepted transaction lost at stage one")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

// self-checking bench for the three-axis pid mixer
// a scoreboard object mirrors the pid and mixer arithmetic and queues the
// expected motor widths, the monitor compares each output transaction
module tb_top;
  import tapm_pkg::*;

  // watchdog: cycles with no transaction on any port before giving up
  localparam int WATCHDOG_LIMIT = 4000;
  // derivative product saturates to the 33 bit signed range
  localparam longint DERIV_HI = (64'sd1 <<< 32) - 64'sd1;
  localparam longint DERIV_LO = -(64'sd1 <<< 32);
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 190;

  // one control update as it travels on the slave stream
  typedef struct packed {
    logic [10:0] throttle;
    logic        launch;
    logic        tick;
    logic [15:0] angle_x;
    logic [15:0] angle_y;
    logic [15:0] angle_z;
    logic [15:0] roll_target;
    logic [15:0] pitch_target;
    logic [15:0] yaw_target;
  } update_t;

  // four motor pulse widths in us
  typedef struct packed {
    logic [10:0] left_front;
    logic [10:0] right_front;
    logic [10:0] left_back;
    logic [10:0] right_back;
  } motors_t;

  // mirrors gains, limits and per-axis state; axis 0 roll, 1 pitch, 2 yaw
  class motor_mix_scoreboard;
    bit [15:0] gain_q [6];
    bit [9:0]  limit_us [2];
    longint    integ_acc [3];
    longint    deriv_hold [3];
    longint    prev_err [3];
    motors_t   pending_motors [$];
    int        fail_count;

    function new();
      for (int i = 0; i < 6; i++) gain_q[i] = '0;
      limit_us[0] = LIMIT_RESET;
      limit_us[1] = LIMIT_RESET;
      clear_axes();
      fail_count = 0;
    endfunction

    function void clear_axes();
      for (int a = 0; a < 3; a++) begin
        integ_acc[a]  = 0;
        deriv_hold[a] = 0;
        prev_err[a]   = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_TILT_P, REG_TILT_I, REG_TILT_D,
        REG_HEADING_P, REG_HEADING_I, REG_HEADING_D: gain_q[idx] = data[15:0];
        REG_TILT_LIMIT:    limit_us[0] = data[9:0];
        REG_HEADING_LIMIT: limit_us[1] = data[9:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [CFG_IDX_W-1:0] idx);
      case (idx)
        REG_TILT_LIMIT:    return {22'd0, limit_us[0]};
        REG_HEADING_LIMIT: return {22'd0, limit_us[1]};
        default:           return {16'd0, gain_q[idx]};
      endcase
    endfunction

    function longint clamp_sym(longint x, longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
    endfunction

    function logic [10:0] motor_width(longint t);
      longint lo;
      longint hi;
      lo = longint'(MOTOR_MIN) <<< FRAC_BITS;
      hi = longint'(MOTOR_MAX) <<< FRAC_BITS;
      if (t < lo) t = lo;
      if (t > hi) t = hi;
      return 11'(t >>> FRAC_BITS);
    endfunction

    // advance the axis state for one accepted update and queue its motors
    function void note_update(update_t u);
      longint  err [3];
      longint  total [3];
      longint  kp, ki, kd, lim, d, base;
      int      g;
      motors_t m;
      if (u.throttle <= IDLE_THROTTLE) begin
        clear_axes();
        m.left_front  = MOTOR_OFF;
        m.right_front = MOTOR_OFF;
        m.left_back   = MOTOR_OFF;
        m.right_back  = MOTOR_OFF;
        pending_motors.push_back(m);
        return;
      end
      err[0] = longint'($signed(u.roll_target)) - longint'($signed(u.angle_y));
      err[1] = longint'($signed(u.pitch_target)) - longint'($signed(u.angle_z));
      err[2] = longint'($signed(u.yaw_target)) - longint'($signed(u.angle_x));
      for (int a = 0; a < 3; a++) begin
        g   = (a == 2) ? 3 : 0;
        kp  = longint'(gain_q[g]);
        ki  = longint'(gain_q[g + 1]);
        kd  = longint'(gain_q[g + 2]);
        lim = longint'(limit_us[(a == 2) ? 1 : 0]) <<< FRAC_BITS;
        if (u.tick) begin
          integ_acc[a] = u.launch ? 0 : clamp_sym(integ_acc[a] + ki * err[a], lim);
          d = kd * (err[a] - prev_err[a]);
          if (d > DERIV_HI) d = DERIV_HI;
          if (d < DERIV_LO) d = DERIV_LO;
          deriv_hold[a] = d;
          prev_err[a]   = err[a];
        end
        total[a] = clamp_sym(kp * err[a] + integ_acc[a] + deriv_hold[a], lim);
      end
      base = longint'(u.throttle) <<< FRAC_BITS;
      m.left_front  = motor_width(base + total[0] + total[1] - total[2]);
      m.right_front = motor_width(base - total[0] + total[1] + total[2]);
      m.left_back   = motor_width(base + total[0] - total[1] + total[2]);
      m.right_back  = motor_width(base - total[0] - total[1] - total[2]);
      pending_motors.push_back(m);
    endfunction

    function void check_motors(motors_t got);
      motors_t want;
      if (pending_motors.size() == 0) begin
        $error("motor transaction with nothing expected: %h", got);
        fail_count++;
        return;
      end
      want = pending_motors.pop_front();
      if (got.left_front !== want.left_front) begin
        $error("motor_left_front expected %0d got %0d", want.left_front, got.left_front);
        fail_count++;
      end
      if (got.right_front !== want.right_front) begin
        $error("motor_right_front expected %0d got %0d", want.right_front, got.right_front);
        fail_count++;
      end
      if (got.left_back !== want.left_back) begin
        $error("motor_left_back expected %0d got %0d", want.left_back, got.left_back);
        fail_count++;
      end
      if (got.right_back !== want.right_back) begin
        $error("motor_right_back expected %0d got %0d", want.right_back, got.right_back);
        fail_count++;
      end
    endfunction

    function int pending();
      return pending_motors.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // throttle_us, angle_x, angle_y, angle_z, roll_target, pitch_target,
  // yaw_target, zero pad
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  // launch_hold, period_tick
  logic [IN_TUSER_W-1:0] s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // motor_left_front, motor_right_front, motor_left_back, motor_right_back,
  // zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  motor_mix_scoreboard sb;
  // register words for the next configuration phase, upper bits may be junk
  logic [31:0] cfg_words [8];
  // chance in percent that the sink starts a stall at a given cycle
  int sink_idle_pct = 0;
  int sink_hold = 0;
  int quiet_cycles = 0;

  three_axis_pid_motor_mixer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // sink side: random stalls, with high stretches in between
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
    end else if (m_axis_tready) begin
      if ($urandom_range(0, 99) < sink_idle_pct) begin
        m_axis_tready <= 1'b0;
        sink_hold = $urandom_range(0, 11);
      end
    end else begin
      m_axis_tready <= 1'b1;
      sink_hold = $urandom_range(0, 15);
    end
  end

  // output monitor: every accepted motor transaction is checked in order
  always @(posedge clk_i) begin
    motors_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.left_front  = m_axis_tdata[10:0];
      got.right_front = m_axis_tdata[21:11];
      got.left_back   = m_axis_tdata[32:22];
      got.right_back  = m_axis_tdata[43:33];
      sb.check_motors(got);
    end
  end

  // watchdog: a long stretch with no transaction anywhere means a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // register write: setup phase, access phase, then an idle phase
  task automatic apb_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [CFG_IDX_W-1:0] idx, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // read data is valid at the access edge
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // read every register back and compare with the mirrored value
  task automatic verify_regs();
    logic [31:0] rd;
    for (int i = 0; i < 8; i++) begin
      apb_read(CFG_IDX_W'(i), rd);
      if (rd !== sb.reg_value(CFG_IDX_W'(i))) begin
        $error("register %0d expected %0d got %0d", i, sb.reg_value(CFG_IDX_W'(i)), rd);
        sb.fail_count++;
      end
    end
  endtask

  task automatic apply_config();
    for (int i = 0; i < 8; i++) apb_write(CFG_IDX_W'(i), cfg_words[i]);
    verify_regs();
  endtask

  // present one update, with an optional random gap ahead of it
  task automatic send_update(input update_t u, input int gap_pct);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, u.yaw_target, u.pitch_target, u.roll_target,
                      u.angle_z, u.angle_y, u.angle_x, u.throttle};
    s_axis_tuser  <= {u.tick, u.launch};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_update(u);
  endtask

  // stop sending, wait until every expected transaction came back, let the
  // pipeline settle for its latency
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic update_t mk_update(int thr, bit launch, bit tick, int ax, int ay,
                                        int az, int rt, int pt, int yt);
    update_t u;
    u.throttle     = 11'(thr);
    u.launch       = launch;
    u.tick         = tick;
    u.angle_x      = 16'(ax);
    u.angle_y      = 16'(ay);
    u.angle_z      = 16'(az);
    u.roll_target  = 16'(rt);
    u.pitch_target = 16'(pt);
    u.yaw_target   = 16'(yt);
    return u;
  endfunction

  function automatic logic [15:0] angle_in_range();
    return 16'($urandom_range(0, 46080) - 23040);
  endfunction

  // target near the measured angle, so most totals stay out of the clamp
  function automatic logic [15:0] near(logic [15:0] base, int spread);
    return base + 16'($urandom_range(0, 2 * spread) - spread);
  endfunction

  function automatic update_t random_update();
    update_t u;
    int      pick;
    int      spread;
    pick = $urandom_range(0, 99);
    if (pick < 10) u.throttle = 11'($urandom_range(0, 1050));
    else if (pick < 13) u.throttle = (pick == 10) ? IDLE_THROTTLE : IDLE_THROTTLE + 11'd1;
    else u.throttle = 11'($urandom_range(1051, 2047));
    u.tick   = ($urandom_range(0, 99) < 40);
    u.launch = ($urandom_range(0, 99) < 15);
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      // any bit pattern, errors up to the full 17 bit range
      u.angle_x      = 16'($urandom());
      u.angle_y      = 16'($urandom());
      u.angle_z      = 16'($urandom());
      u.roll_target  = 16'($urandom());
      u.pitch_target = 16'($urandom());
      u.yaw_target   = 16'($urandom());
    end else if (pick < 4) begin
      u.angle_x      = angle_in_range();
      u.angle_y      = angle_in_range();
      u.angle_z      = angle_in_range();
      u.roll_target  = angle_in_range();
      u.pitch_target = angle_in_range();
      u.yaw_target   = angle_in_range();
    end else begin
      spread = ($urandom_range(0, 1) == 0) ? 63 : 2047;
      u.angle_x      = angle_in_range();
      u.angle_y      = angle_in_range();
      u.angle_z      = angle_in_range();
      u.roll_target  = near(u.angle_y, spread);
      u.pitch_target = near(u.angle_z, spread);
      u.yaw_target   = near(u.angle_x, spread);
    end
    return u;
  endfunction

  // random register word; bits above the register width are junk on purpose
  function automatic logic [31:0] random_gain_word();
    logic [15:0] g;
    case ($urandom_range(0, 3))
      0:       g = 16'($urandom_range(0, 255));
      1:       g = 16'($urandom_range(0, 2047));
      2:       g = 16'($urandom());
      default: g = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
    endcase
    return {16'($urandom()), g};
  endfunction

  initial begin
    int gap_pct;
    sb = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of all registers
    verify_regs();

    // reset gains: every motor follows the throttle inside its clamp, or is off at idle throttle
    sink_idle_pct = 30;
    send_update(mk_update(0, 0, 0, 0, 0, 0, 0, 0, 0), 30);
    send_update(mk_update(1050, 1, 1, 100, -200, 300, 0, 0, 0), 30);
    send_update(mk_update(1051, 0, 1, 100, 200, 300, -100, -200, -300), 30);
    send_update(mk_update(2047, 1, 0, 23040, -23040, 23040, -23040, 23040, -23040), 30);
    send_update(mk_update(1500, 0, 1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                          16'h8000), 30);
    drain_outputs();

    // full-scale tilt derivative gain and limits of 1000 us and above
    cfg_words[REG_TILT_P]        = 32'd256;
    cfg_words[REG_TILT_I]        = 32'd40;
    cfg_words[REG_TILT_D]        = 32'h0000_FFFF;
    cfg_words[REG_HEADING_P]     = 32'd512;
    cfg_words[REG_HEADING_I]     = 32'h0000_FFFF;
    cfg_words[REG_HEADING_D]     = 32'd300;
    cfg_words[REG_TILT_LIMIT]    = 32'd1023;
    cfg_words[REG_HEADING_LIMIT] = 32'd1000;
    apply_config();
    // roll error at its most negative, then swung to the most positive and
    // back: the derivative product saturates both ways
    send_update(mk_update(1500, 0, 1, 0, 16'h7FFF, 0, 16'h8000, 0, 0), 30);
    send_update(mk_update(1500, 0, 1, 0, 16'h8000, 0, 16'h7FFF, 0, 0), 30);
    send_update(mk_update(1500, 0, 1, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                          16'h7FFF), 30);
    // launch without a tick leaves the integrals alone
    send_update(mk_update(1500, 1, 0, 10, 20, 30, 40, 50, 60), 30);
    // launch on a tick clears them
    send_update(mk_update(1500, 1, 1, 10, 20, 30, 40, 50, 60), 30);
    send_update(mk_update(1600, 0, 1, 23040, -23040, 23040, 23040, -23040, -23040), 30);
    send_update(mk_update(1600, 0, 1, 500, -300, 200, 700, -100, 100), 30);
    // idle throttle wipes every axis state, ticks after it start from zero
    send_update(mk_update(1000, 1, 1, 500, -300, 200, 700, -100, 100), 30);
    send_update(mk_update(1600, 0, 0, 500, -300, 200, 700, -100, 100), 30);
    send_update(mk_update(1600, 0, 1, 500, -300, 200, 700, -100, 100), 30);
    send_update(mk_update(1200, 0, 1, 0, 0, -640, 0, 640, 0), 30);
    send_update(mk_update(1999, 0, 1, -64, 64, 0, 64, -64, 0), 30);
    drain_outputs();

    // random phases, each with its own register setting and idle pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int i = 0; i < 8; i++) begin
        case (ph)
          // every gain and limit at its top, junk in the upper bits
          0: cfg_words[i] = 32'hFFFF_FFFF;
          // all zero
          1: cfg_words[i] = 32'd0;
          // full gains against zero limits
          2: cfg_words[i] = (i >= REG_TILT_LIMIT) ? 32'd0 : 32'h0000_FFFF;
          default: cfg_words[i] = (i >= REG_TILT_LIMIT) ?
                                  {22'($urandom()), 10'($urandom_range(0, 1023))} :
                                  random_gain_word();
        endcase
      end
      apply_config();
      // no idling on either side in the last phase
      if (ph == PHASES - 1) begin
        gap_pct = 0;
        sink_idle_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          2:       gap_pct = 30;
          default: gap_pct = 60;
        endcase
        sink_idle_pct = $urandom_range(0, 3) * 15;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_update(random_update(), gap_pct);
      drain_outputs();
    end

    repeat (20) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
